// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for concurrent checks; they expand to nothing under SYNTH.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication: whenever ante holds, cons must hold too
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication: whenever ante holds, cons must hold in the following cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/smcr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smcr_pkg
// Shared widths and constants of the SPI command/response master.
// ----------------------------------------------------------------------------
package smcr_pkg;

  localparam int COMMAND_BITS     = 32;
  localparam int RESPONSE_BITS    = 8;
  localparam int READY_WAIT_LIMIT = 1000;

  localparam int DIV_W  = 16;
  localparam int BIT_W  = $clog2(COMMAND_BITS + 1);
  localparam int WAIT_W = $clog2(READY_WAIT_LIMIT + 1);

  localparam logic [DIV_W-1:0]  DIV_RESET  = DIV_W'(4);
  localparam logic [DIV_W-1:0]  DIV_MIN    = DIV_W'(2);
  localparam logic [BIT_W-1:0]  CMD_END    = BIT_W'(COMMAND_BITS);
  localparam logic [BIT_W-1:0]  RSP_END    = BIT_W'(RESPONSE_BITS);
  localparam logic [WAIT_W-1:0] WAIT_LIMIT = WAIT_W'(READY_WAIT_LIMIT);

endpackage

// ===== hw/rtl/smcr_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smcr_if
// Valid/ready channels of the SPI master: input tick, result and divider write.
// ----------------------------------------------------------------------------

// Input word: one system clock tick of requests and sampled pins
interface smcr_in_if;
  logic                               valid;
  logic                               ready;
  logic                               start_req;
  logic [smcr_pkg::COMMAND_BITS-1:0]  command;
  logic                               miso;

  modport source (output valid, start_req, command, miso, input ready);
  modport sink   (input valid, start_req, command, miso, output ready);
endinterface

// Result word: pin levels and status for that tick
interface smcr_out_if;
  logic                               valid;
  logic                               ready;
  logic                               select_n;
  logic                               serial_clock;
  logic                               mosi;
  logic                               busy_res;
  logic                               done_res;
  logic [smcr_pkg::RESPONSE_BITS-1:0] response;
  logic                               timeout_error;

  modport source (output valid, select_n, serial_clock, mosi, busy_res, done_res,
                  response, timeout_error, input ready);
  modport sink   (input valid, select_n, serial_clock, mosi, busy_res, done_res,
                  response, timeout_error, output ready);
endinterface

// Configuration word: serial clock divider
interface smcr_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [smcr_pkg::DIV_W-1:0]  clock_divider;

  modport source (output valid, clock_divider, input ready);
  modport sink   (input valid, clock_divider, output ready);
endinterface

// ===== hw/rtl/spi_master_command_response.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_master_command_response
// SPI mode 0 master: sends a command word, polls for a ready bit, reads back
// a response byte. Every input word is one system clock tick.
// ----------------------------------------------------------------------------
//  channel   dir  payload
//  in_chan   in   start_req, command, miso
//  out_chan  out  select_n, serial_clock, mosi, busy_res, done_res,
//                 response, timeout_error
//  cfg_chan  in   clock_divider (always ready)
//
//  One input word per cycle while in_ready is high; its result word sits in the output
//  register from the next cycle. The single output register sets the pace: in_ready
//  is high whenever the register is empty or being drained.
//  Reset (synchronous, rst_n low) gives idle, divider 4, empty result register.
//  A stall on out_chan stops acceptance; the serial state only moves on accepted words.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spi_master_command_response (
  input  logic         clk,
  input  logic         rst_n,
  smcr_in_if.sink      in_chan,
  smcr_out_if.source   out_chan,
  smcr_cfg_if.sink     cfg_chan
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_TX_LOW, PH_TX_HIGH, PH_WAIT_LOW,
    PH_WAIT_HIGH, PH_RX_HIGH, PH_RX_LOW, PH_DESEL
  } phase_t;

  // serial state
  phase_t                              phase_r, phase_nxt;
  logic [smcr_pkg::DIV_W-1:0]          half_r, half_nxt;
  logic [smcr_pkg::BIT_W-1:0]          bit_r, bit_nxt;
  logic [smcr_pkg::COMMAND_BITS-1:0]   tx_r, tx_nxt;
  logic [smcr_pkg::WAIT_W-1:0]         wait_r, wait_nxt;
  logic [smcr_pkg::RESPONSE_BITS-1:0]  rx_r, rx_nxt;
  logic                                err_r, err_nxt;
  logic [smcr_pkg::DIV_W-1:0]          div_r;

  // result register
  logic                                out_valid_r;
  logic                                sel_r, sel_nxt;
  logic                                sclk_r, sclk_nxt;
  logic                                mosi_r, mosi_nxt;
  logic                                busy_r, busy_nxt;
  logic                                done_r, done_nxt;
  logic [smcr_pkg::RESPONSE_BITS-1:0]  resp_r, resp_nxt;
  logic                                terr_r, terr_nxt;

  logic                                in_acc;
  logic [smcr_pkg::DIV_W-1:0]          div_eff, lo_ticks, hi_ticks, half_dec;
  phase_t                              ph_cur;
  logic [smcr_pkg::BIT_W-1:0]          bit_inc;
  logic [smcr_pkg::WAIT_W-1:0]         wait_inc;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;

  // divider below two runs as two; low half is the floor
  assign div_eff  = (div_r < smcr_pkg::DIV_MIN) ? smcr_pkg::DIV_MIN : div_r;
  assign lo_ticks = div_eff >> 1;
  assign hi_ticks = div_eff - lo_ticks;

  // half-period length of a freshly entered phase
  function automatic logic [smcr_pkg::DIV_W-1:0] half_len(
    input phase_t                     ph,
    input logic [smcr_pkg::DIV_W-1:0] lo,
    input logic [smcr_pkg::DIV_W-1:0] hi,
    input logic [smcr_pkg::DIV_W-1:0] d
  );
    logic [smcr_pkg::DIV_W-1:0] n;
    case (ph)
      PH_TX_LOW, PH_WAIT_LOW, PH_RX_LOW:    n = lo;
      PH_TX_HIGH, PH_WAIT_HIGH, PH_RX_HIGH: n = hi;
      PH_DESEL:                             n = d;
      default:                              n = '0;
    endcase
    return n;
  endfunction

  // one tick of the transaction
  always_comb begin
    phase_nxt = phase_r;
    half_nxt  = half_r;
    bit_nxt   = bit_r;
    tx_nxt    = tx_r;
    wait_nxt  = wait_r;
    rx_nxt    = rx_r;
    err_nxt   = err_r;
    ph_cur    = phase_r;
    sel_nxt   = 1'b1;
    sclk_nxt  = 1'b0;
    mosi_nxt  = 1'b0;
    busy_nxt  = 1'b0;
    done_nxt  = 1'b0;
    resp_nxt  = '0;
    terr_nxt  = 1'b0;
    half_dec  = '0;
    bit_inc   = bit_r + 1'b1;
    wait_inc  = wait_r + 1'b1;

    if (phase_r != PH_IDLE || in_chan.start_req) begin
      // start: capture command and open the first low half
      if (phase_r == PH_IDLE) begin
        tx_nxt   = in_chan.command;
        bit_nxt  = '0;
        wait_nxt = '0;
        rx_nxt   = '0;
        err_nxt  = 1'b0;
        ph_cur   = PH_TX_LOW;
        half_nxt = lo_ticks;
      end
      bit_inc  = bit_nxt + 1'b1;
      wait_inc = wait_nxt + 1'b1;

      // pin levels follow the phase
      sel_nxt  = (ph_cur == PH_DESEL);
      sclk_nxt = ph_cur inside {PH_TX_HIGH, PH_WAIT_HIGH, PH_RX_HIGH};
      mosi_nxt = (ph_cur inside {PH_TX_LOW, PH_TX_HIGH}) &&
                 tx_nxt[smcr_pkg::COMMAND_BITS-1];
      busy_nxt = 1'b1;

      half_dec  = (half_nxt != '0) ? half_nxt - 1'b1 : half_nxt;
      half_nxt  = half_dec;
      phase_nxt = ph_cur;

      // end of a half period
      if (half_dec == '0) begin
        case (ph_cur)
          PH_TX_LOW: phase_nxt = PH_TX_HIGH;
          PH_TX_HIGH: begin
            tx_nxt  = tx_nxt << 1;
            bit_nxt = bit_inc;
            if (bit_inc >= smcr_pkg::CMD_END) begin
              wait_nxt  = '0;
              phase_nxt = PH_WAIT_LOW;
            end else begin
              phase_nxt = PH_TX_LOW;
            end
          end
          PH_WAIT_LOW: begin
            if (in_chan.miso) begin
              bit_nxt   = '0;
              rx_nxt    = '0;
              phase_nxt = PH_RX_HIGH;
            end else begin
              phase_nxt = PH_WAIT_HIGH;
            end
          end
          PH_WAIT_HIGH: begin
            wait_nxt = wait_inc;
            if (wait_inc >= smcr_pkg::WAIT_LIMIT) begin
              // last chance sample on the final high half
              if (in_chan.miso) begin
                bit_nxt   = '0;
                rx_nxt    = '0;
                phase_nxt = PH_RX_HIGH;
              end else begin
                err_nxt   = 1'b1;
                phase_nxt = PH_DESEL;
              end
            end else begin
              phase_nxt = PH_WAIT_LOW;
            end
          end
          PH_RX_HIGH: phase_nxt = PH_RX_LOW;
          PH_RX_LOW: begin
            rx_nxt  = {rx_nxt[smcr_pkg::RESPONSE_BITS-2:0], in_chan.miso};
            bit_nxt = bit_inc;
            if (bit_inc >= smcr_pkg::RSP_END) begin
              err_nxt   = 1'b0;
              phase_nxt = PH_DESEL;
            end else begin
              phase_nxt = PH_RX_HIGH;
            end
          end
          default: begin
            // end of deselect gap: report
            done_nxt  = 1'b1;
            terr_nxt  = err_nxt;
            resp_nxt  = err_nxt ? '0 : rx_nxt;
            phase_nxt = PH_IDLE;
          end
        endcase
        half_nxt = half_len(phase_nxt, lo_ticks, hi_ticks, div_eff);
      end
    end
  end

  // state, divider and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      half_r      <= '0;
      bit_r       <= '0;
      tx_r        <= '0;
      wait_r      <= '0;
      rx_r        <= '0;
      err_r       <= 1'b0;
      div_r       <= smcr_pkg::DIV_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_chan.valid) begin
        div_r <= cfg_chan.clock_divider;
      end
      if (in_acc) begin
        phase_r     <= phase_nxt;
        half_r      <= half_nxt;
        bit_r       <= bit_nxt;
        tx_r        <= tx_nxt;
        wait_r      <= wait_nxt;
        rx_r        <= rx_nxt;
        err_r       <= err_nxt;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sel_r  <= sel_nxt;
      sclk_r <= sclk_nxt;
      mosi_r <= mosi_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      resp_r <= resp_nxt;
      terr_r <= terr_nxt;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.select_n      = sel_r;
  assign out_chan.serial_clock  = sclk_r;
  assign out_chan.mosi          = mosi_r;
  assign out_chan.busy_res      = busy_r;
  assign out_chan.done_res      = done_r;
  assign out_chan.response      = resp_r;
  assign out_chan.timeout_error = terr_r;

  // checks
  `ASSERT_NEXT(a_done_goes_idle, clk, rst_n, in_acc && done_nxt, phase_r == PH_IDLE)
  `ASSERT_IMPL(a_done_busy, clk, rst_n, out_valid_r && done_r, busy_r && sel_r && !sclk_r)
  `ASSERT_IMPL(a_timeout_no_resp, clk, rst_n, out_valid_r && terr_r, resp_r == '0 && done_r)
  `ASSERT_IMPL(a_wait_bound, clk, rst_n, 1'b1, wait_r <= smcr_pkg::WAIT_LIMIT)

endmodule
